// File: rtl/bsal_pkg.sv
// Shared types and constants for the any-length bitonic sorter.
`default_nettype none
package bsal_pkg;

  // Fixed field widths on the stream ports
  localparam int FIELD_W = 64;
  localparam int TDATA_W = 2 * FIELD_W;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_XRD,
    ST_XWA,
    ST_XWB,
    ST_ERD,
    ST_ELD
  } state_t;

  // Kind of a network frame on the recursion stack
  typedef enum logic {
    FR_SORT,
    FR_MERGE
  } frame_kind_t;

  // Frame progress
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_XRD,
    DP_XWA,
    DP_XWB,
    DP_ORD,
    DP_OLD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   up;
    logic   last;
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/bsal_datapath.sv
// Record store, compare-exchange unit and output register of the sorter.
`default_nettype none
module bsal_datapath import bsal_pkg::*; #(
  parameter int MAX_ITEMS     = 64,
  parameter int KEY_WIDTH     = 64,
  parameter int PAYLOAD_WIDTH = 64,
  localparam int IDX_W        = $clog2(MAX_ITEMS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  input  wire logic [IDX_W-1:0]   addr_a,
  input  wire logic [IDX_W-1:0]   addr_b,
  input  wire logic [FIELD_W-1:0] ld_key,
  input  wire logic [FIELD_W-1:0] ld_payload,
  input  wire logic               ld_dummy,
  output logic                    out_free,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,   // out_key, out_payload
  output logic                    out_tuser,   // out_dummy
  output logic                    out_tlast    // out_last
);

  logic [KEY_WIDTH-1:0]     key_mem [MAX_ITEMS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [MAX_ITEMS];
  logic                     dum_mem [MAX_ITEMS];

  logic [KEY_WIDTH-1:0]     rd_a_key_r, rd_b_key_r;
  logic [PAYLOAD_WIDTH-1:0] rd_a_pay_r, rd_b_pay_r;
  logic                     rd_a_dum_r, rd_b_dum_r;
  logic                     swap_r;

  logic [KEY_WIDTH-1:0]     o_key_r;
  logic [PAYLOAD_WIDTH-1:0] o_pay_r;
  logic                     o_dum_r, o_last_r, o_valid_r;

  logic                     swap_nxt;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [KEY_WIDTH-1:0]     wr_key;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;
  logic                     wr_dum;

  // Ascending swaps on greater, descending on less or equal
  assign swap_nxt = cmd.up ? (rd_a_key_r > rd_b_key_r) : !(rd_a_key_r > rd_b_key_r);

  // Select the write beat
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_a;
    wr_key  = rd_a_key_r;
    wr_pay  = rd_a_pay_r;
    wr_dum  = rd_a_dum_r;
    unique case (cmd.op)
      DP_LOAD: begin
        wr_en  = 1'b1;
        wr_key = ld_key[KEY_WIDTH-1:0];
        wr_pay = ld_payload[PAYLOAD_WIDTH-1:0];
        wr_dum = ld_dummy;
      end
      DP_XWA: begin
        wr_en = 1'b1;
        if (swap_nxt) begin
          wr_key = rd_b_key_r;
          wr_pay = rd_b_pay_r;
          wr_dum = rd_b_dum_r;
        end
      end
      DP_XWB: begin
        wr_en   = 1'b1;
        wr_addr = addr_b;
        if (!swap_r) begin
          wr_key = rd_b_key_r;
          wr_pay = rd_b_pay_r;
          wr_dum = rd_b_dum_r;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store ports: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
      dum_mem[wr_addr] <= wr_dum;
    end
    if (cmd.op == DP_XRD || cmd.op == DP_ORD) begin
      rd_a_key_r <= key_mem[addr_a];
      rd_a_pay_r <= pay_mem[addr_a];
      rd_a_dum_r <= dum_mem[addr_a];
      rd_b_key_r <= key_mem[addr_b];
      rd_b_pay_r <= pay_mem[addr_b];
      rd_b_dum_r <= dum_mem[addr_b];
    end
    if (cmd.op == DP_XWA) begin
      swap_r <= swap_nxt;
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (cmd.op == DP_OLD) begin
      o_valid_r <= 1'b1;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OLD) begin
      o_key_r  <= rd_a_key_r;
      o_pay_r  <= rd_a_pay_r;
      o_dum_r  <= rd_a_dum_r;
      o_last_r <= cmd.last;
    end
  end

  assign out_free   = !o_valid_r || out_tready;
  assign out_tvalid = o_valid_r;
  assign out_tdata  = {FIELD_W'(o_pay_r), FIELD_W'(o_key_r)};
  assign out_tuser  = o_dum_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

// File: rtl/bsal_ctrl.sv
// Sequencer for the sorter: load count, network recursion stack and emission.
`default_nettype none
module bsal_ctrl import bsal_pkg::*; #(
  parameter int MAX_ITEMS = 64,
  localparam int IDX_W    = $clog2(MAX_ITEMS),
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tlast,
  input  wire logic             out_free,
  output dp_cmd_t               cmd,
  output logic [IDX_W-1:0]      addr_a,
  output logic [IDX_W-1:0]      addr_b
);

  localparam int STK_DEPTH = 2 * IDX_W + 4;
  localparam int STK_W     = $clog2(STK_DEPTH);
  localparam int SP_W      = $clog2(STK_DEPTH + 1);

  typedef struct packed {
    frame_kind_t     kind;
    phase_t          phase;
    logic            up;
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] len;
  } frame_t;

  // Largest power of two strictly below v (v of two or more)
  function automatic logic [CNT_W-1:0] pow2_below(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] d;
    logic [CNT_W-1:0] r;
    d = v - CNT_W'(1);
    r = '0;
    for (int j = 0; j < CNT_W; j++) begin
      if (d[j]) r = CNT_W'(1) << j;
    end
    return r;
  endfunction

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic             asc_r;
  frame_t           stk_r [STK_DEPTH];

  frame_t           top, top_val, push_val;
  logic             top_we, push_we;
  logic [STK_W-1:0] top_idx;
  logic [CNT_W-1:0] m, half, nx, pa, pb;

  assign top_idx = STK_W'(sp_r - SP_W'(1));
  assign top     = stk_r[top_idx];
  assign m       = pow2_below(top.len);
  assign half    = top.len >> 1;
  assign nx      = top.len - m;
  assign pa      = CNT_W'(top.base) + CNT_W'(idx_r);
  assign pb      = pa + m;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    sp_nxt    = sp_r;
    top_we    = 1'b0;
    push_we   = 1'b0;
    top_val   = top;
    push_val  = top;
    cmd.op    = DP_NOP;
    cmd.up    = top.up;
    cmd.last  = 1'b0;
    addr_a    = pa[IDX_W-1:0];
    addr_b    = pb[IDX_W-1:0];
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        addr_a    = cnt_r[IDX_W-1:0];
        if (in_tvalid) begin
          if (cnt_r != CNT_W'(MAX_ITEMS)) begin
            cmd.op  = DP_LOAD;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            // Open the whole run as one sort frame
            push_we        = 1'b1;
            push_val.kind  = FR_SORT;
            push_val.phase = PH_FIRST;
            push_val.up    = asc_r;
            push_val.base  = '0;
            push_val.len   = cnt_nxt;
            sp_nxt         = SP_W'(1);
            state_nxt      = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_ERD;
        end else if (top.len <= CNT_W'(1)) begin
          sp_nxt = sp_r - SP_W'(1);
        end else if (top.kind == FR_SORT) begin
          unique case (top.phase)
            PH_FIRST: begin
              top_we         = 1'b1;
              top_val.phase  = PH_SECOND;
              push_we        = 1'b1;
              push_val.phase = PH_FIRST;
              push_val.up    = !top.up;
              push_val.len   = half;
              sp_nxt         = sp_r + SP_W'(1);
            end
            PH_SECOND: begin
              top_we         = 1'b1;
              top_val.phase  = PH_THIRD;
              push_we        = 1'b1;
              push_val.phase = PH_FIRST;
              push_val.base  = top.base + half[IDX_W-1:0];
              push_val.len   = top.len - half;
              sp_nxt         = sp_r + SP_W'(1);
            end
            default: begin
              top_we        = 1'b1;
              top_val.kind  = FR_MERGE;
              top_val.phase = PH_FIRST;
            end
          endcase
        end else begin
          unique case (top.phase)
            PH_FIRST: begin
              idx_nxt   = '0;
              state_nxt = ST_XRD;
            end
            PH_SECOND: begin
              top_we         = 1'b1;
              top_val.phase  = PH_THIRD;
              push_we        = 1'b1;
              push_val.phase = PH_FIRST;
              push_val.len   = m;
              sp_nxt         = sp_r + SP_W'(1);
            end
            default: begin
              top_we        = 1'b1;
              top_val.phase = PH_FIRST;
              top_val.base  = top.base + m[IDX_W-1:0];
              top_val.len   = nx;
            end
          endcase
        end
      end
      ST_XRD: begin
        cmd.op    = DP_XRD;
        state_nxt = ST_XWA;
      end
      ST_XWA: begin
        cmd.op    = DP_XWA;
        state_nxt = ST_XWB;
      end
      ST_XWB: begin
        cmd.op = DP_XWB;
        if (CNT_W'(idx_r) + CNT_W'(1) == nx) begin
          top_we        = 1'b1;
          top_val.phase = PH_SECOND;
          state_nxt     = ST_SORT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_XRD;
        end
      end
      ST_ERD: begin
        cmd.op    = DP_ORD;
        addr_a    = k_r;
        state_nxt = ST_ELD;
      end
      ST_ELD: begin
        addr_a = k_r;
        if (out_free) begin
          cmd.op   = DP_OLD;
          cmd.last = (CNT_W'(k_r) + CNT_W'(1) == cnt_r);
          if (cmd.last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      sp_r    <= '0;
      asc_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sp_r    <= sp_nxt;
      if (cfg_wr_en) asc_r <= cfg_wr_data;
    end
  end

  // Counters and recursion stack
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    if (top_we) stk_r[top_idx] <= top_val;
    if (push_we) stk_r[STK_W'(state_r == ST_LOAD ? SP_W'(0) : sp_r)] <= push_val;
  end

endmodule
`default_nettype wire

// File: rtl/bitonic_sort_any_length.sv
// Bitonic sorter for runs of any length up to MAX_ITEMS records.
// Load: one record per cycle; the last record starts the sort.
// Sort: each compare-exchange is one read beat and two write beats; every network frame of
// two or more records steps through its phases on the recursion stack, shorter frames are popped.
// Emit: each sorted record is a store read then an output load, held under backpressure.
// Reset (rst_n low, synchronous) empties the run and sets ascending order.
`default_nettype none
module bitonic_sort_any_length import bsal_pkg::*; #(
  parameter int MAX_ITEMS     = 64,
  parameter int KEY_WIDTH     = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,  // ascending
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,     // sort_key, payload
  input  wire logic               in_tuser,     // dummy_mark
  input  wire logic               in_tlast,     // last_item
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,    // out_key, out_payload
  output logic                    out_tuser,    // out_dummy
  output logic                    out_tlast     // out_last
);

  localparam int IDX_W = $clog2(MAX_ITEMS);

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] addr_a, addr_b;
  logic             out_free;

  bsal_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_free   (out_free),
    .cmd        (cmd),
    .addr_a     (addr_a),
    .addr_b     (addr_b)
  );

  bsal_datapath #(
    .MAX_ITEMS    (MAX_ITEMS),
    .KEY_WIDTH    (KEY_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .ld_key    (in_tdata[FIELD_W-1:0]),
    .ld_payload(in_tdata[TDATA_W-1:FIELD_W]),
    .ld_dummy  (in_tuser),
    .out_free  (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the any-length bitonic sorter.
`timescale 1ns / 1ps
module testbench;
  import bsal_pkg::*;

  localparam int CAP = 64;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] payload;
    logic        dummy;
    logic        last;
  } rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  bitonic_sort_any_length u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic [63:0] run_key [CAP];
  logic [63:0] run_pay [CAP];
  logic        run_dum [CAP];
  int          run_len = 0;
  logic        order_up = 1'b1;
  rec_t        sorted_q[$];
  int          errors = 0;
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  longint      cycles = 0;

  function automatic int pow2_under(int n);
    int k;
    k = 1;
    while (k < n) k = k * 2;
    return k / 2;
  endfunction

  function automatic void swap_pair(int a, int b, bit up);
    logic [63:0] t;
    logic d;
    if (up == (run_key[a] > run_key[b])) begin
      t = run_key[a]; run_key[a] = run_key[b]; run_key[b] = t;
      t = run_pay[a]; run_pay[a] = run_pay[b]; run_pay[b] = t;
      d = run_dum[a]; run_dum[a] = run_dum[b]; run_dum[b] = d;
    end
  endfunction

  function automatic void merge_span(int base, int len, bit up);
    int m;
    if (len <= 1) return;
    m = pow2_under(len);
    for (int i = base; i < base + len - m; i++) swap_pair(i, i + m, up);
    merge_span(base, m, up);
    merge_span(base + m, len - m, up);
  endfunction

  function automatic void sort_span(int base, int len, bit up);
    int h;
    if (len <= 1) return;
    h = len / 2;
    sort_span(base, h, !up);
    sort_span(base + h, len - h, up);
    merge_span(base, len, up);
  endfunction

  // Model one accepted record
  function automatic void predict_record(logic [63:0] k, logic [63:0] p, logic d, logic l);
    rec_t r;
    if (run_len < CAP) begin
      run_key[run_len] = k; run_pay[run_len] = p; run_dum[run_len] = d;
      run_len++;
    end
    if (l) begin
      sort_span(0, run_len, order_up);
      for (int i = 0; i < run_len; i++) begin
        r.key = run_key[i]; r.payload = run_pay[i]; r.dummy = run_dum[i];
        r.last = (i == run_len - 1);
        sorted_q.push_back(r);
      end
      run_len = 0;
    end
  endfunction

  // Receiver: random stall and result check
  always @(posedge clk) begin
    rec_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_n) begin
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tuser, out_tlast};
        if (sorted_q.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected beat %h", got);
          mismatches++;
        end else begin
          exp_r = sorted_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: exp key %h pay %h d %b l %b, got key %h pay %h d %b l %b",
                       exp_r.key, exp_r.payload, exp_r.dummy, exp_r.last,
                       got.key, got.payload, got.dummy, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one record, idling at random first; the beat stays up after acceptance
  task automatic send_record(logic [63:0] k, logic [63:0] p, logic d, logic l);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {p, k};
    in_tuser <= d;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    predict_record(k, p, d, l);
  endtask

  // Drop the input, wait for drain, then set sort order
  task automatic set_order(bit up);
    in_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= up;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_up = up;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'(($urandom_range(3)));
      2: return {32'hFFFFFFFF, $urandom | 32'hFFFFFFF0};
      default: return {$urandom_range(1) != 0, 31'd0, 32'($urandom_range(7))};
    endcase
  endfunction

  task automatic send_run(int n);
    for (int i = 0; i < n; i++)
      send_record(rand64(), {$urandom, $urandom}, 1'($urandom_range(1)), i == n - 1);
  endtask

  task automatic test_directed();
    send_record(64'd5, 64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1);   // single record
    send_record('1, 64'd0, 1'b0, 1'b0);
    send_record(64'd0, '1, 1'b1, 1'b0);
    send_record(64'd7, 64'd1, 1'b0, 1'b0);
    send_record(64'd7, 64'd2, 1'b1, 1'b1);                  // equal keys
    set_order(1'b0);
    send_record(64'd3, 64'd10, 1'b0, 1'b0);
    send_record(64'd3, 64'd11, 1'b1, 1'b0);
    send_record('1, 64'd12, 1'b0, 1'b0);
    send_record(64'd0, 64'd13, 1'b1, 1'b0);
    send_record(64'd9, 64'd14, 1'b0, 1'b1);
    set_order(1'b1);
  endtask

  task automatic test_overflow();
    // Full store plus dropped records, last one dropped too
    for (int i = 0; i < CAP + 3; i++)
      send_record(rand64(), {$urandom, $urandom}, 1'($urandom_range(1)), i == CAP + 2);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 26) begin
      int n;
      n = int'($urandom_range(1, 12));
      if ($urandom_range(9) == 0) set_order(1'($urandom_range(1)));
      send_run(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_overflow();
    set_order(1'b0);
    // Full-rate stretch on both sides
    no_idle = 1'b1;
    test_overflow();
    set_order(1'b1);
    no_idle = 1'b0;
    test_random();
    in_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
